FILE: hdl/cmap4_pkg.sv
// shared types and constants for the cmap format 4 character to glyph mapper
package cmap4_pkg;

  localparam int DEF_MAX_SEGMENTS = 256;
  localparam int DEF_GLYPH_ARRAY_WORDS = 4096;
  localparam int QUEUE_DEPTH = 4;

  // input item mode codes
  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_SEG    = 2'd1,
    MODE_WORD   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // command codes handed from front to back
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_SEG    = 2'd1,
    OP_WORD   = 2'd2
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        big;
    logic [15:0] ch;
    logic [7:0]  seg_slot;
    logic [15:0] end_code;
    logic [15:0] start_code;
    logic [15:0] id_delta;
    logic [15:0] range_offset;
    logic [11:0] word_slot;
    logic [15:0] word_value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: hdl/cmap4_front.sv
// front end: accepts inputs, drops no-ops and bad slots, builds commands
module cmap4_front #(
  parameter int MAX_SEGMENTS = cmap4_pkg::DEF_MAX_SEGMENTS,
  parameter int GLYPH_ARRAY_WORDS = cmap4_pkg::DEF_GLYPH_ARRAY_WORDS
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        mode,
  input  logic [20:0]       char_code,
  input  logic [7:0]        seg_slot,
  input  logic [15:0]       seg_end_code,
  input  logic [15:0]       seg_start_code,
  input  logic [15:0]       seg_id_delta,
  input  logic [15:0]       seg_range_offset,
  input  logic [11:0]       word_slot,
  input  logic [15:0]       word_value,
  input  cmap4_pkg::q_stat_t q_stat,
  output logic              push,
  output cmap4_pkg::cmd_t   push_cmd
);
  import cmap4_pkg::*;

  logic seg_ok;
  logic word_ok;
  logic keep;

  assign seg_ok  = {9'd0, seg_slot} < 17'(MAX_SEGMENTS);
  assign word_ok = {5'd0, word_slot} < 17'(GLYPH_ARRAY_WORDS);

  always_comb begin
    push_cmd.op = OP_LOOKUP;
    keep = 1'b0;
    unique case (mode_t'(mode))
      MODE_LOOKUP: begin
        push_cmd.op = OP_LOOKUP;
        keep = 1'b1;
      end
      MODE_SEG: begin
        push_cmd.op = OP_SEG;
        keep = seg_ok;
      end
      MODE_WORD: begin
        push_cmd.op = OP_WORD;
        keep = word_ok;
      end
      default: begin
        push_cmd.op = OP_LOOKUP;
        keep = 1'b0;
      end
    endcase
    // codes above the bmp can never meet an end code
    push_cmd.big          = char_code[20:16] != 5'd0;
    push_cmd.ch           = char_code[15:0];
    push_cmd.seg_slot     = seg_slot;
    push_cmd.end_code     = seg_end_code;
    push_cmd.start_code   = seg_start_code;
    push_cmd.id_delta     = seg_id_delta;
    push_cmd.range_offset = seg_range_offset;
    push_cmd.word_slot    = word_slot;
    push_cmd.word_value   = word_value;
  end

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full && keep;

endmodule

FILE: hdl/cmap4_fifo.sv
// short command queue between front and back end
module cmap4_fifo #(
  parameter int WIDTH = $bits(cmap4_pkg::cmd_t)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   push_data,
  input  logic               pop,
  output logic [WIDTH-1:0]   pop_data,
  output cmap4_pkg::q_stat_t q_stat
);
  import cmap4_pkg::*;

  localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [QA-1:0]    wr_ptr;
  logic [QA-1:0]    rd_ptr;
  logic [QC-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign q_stat.full  = count == QC'(QUEUE_DEPTH);
  assign q_stat.empty = count == '0;
  assign do_push  = push && !q_stat.full;
  assign do_pop   = pop && !q_stat.empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QA'(QUEUE_DEPTH - 1)) ? '0 : QA'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QA'(QUEUE_DEPTH - 1)) ? '0 : QA'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= QC'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= QC'(count - 1'b1);
      end
    end
  end

endmodule

FILE: hdl/cmap4_back.sv
// back end: table memories, segment scan sequencer and output register
module cmap4_back #(
  parameter int MAX_SEGMENTS = cmap4_pkg::DEF_MAX_SEGMENTS,
  parameter int GLYPH_ARRAY_WORDS = cmap4_pkg::DEF_GLYPH_ARRAY_WORDS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [8:0]         cfg_data,
  input  cmap4_pkg::q_stat_t q_stat,
  input  cmap4_pkg::cmd_t    head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        glyph_id,
  output logic               index_fault
);
  import cmap4_pkg::*;

  localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SEG_CW = $clog2(MAX_SEGMENTS + 1);
  localparam int GW_AW  = (GLYPH_ARRAY_WORDS > 1) ? $clog2(GLYPH_ARRAY_WORDS) : 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CMP  = 5'b00010,
    ST_IDX  = 5'b00100,
    ST_GRD  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [8:0]        segment_count;
  logic [SEG_CW-1:0] n_seg;
  logic [SEG_CW-1:0] s, s_next;
  logic [15:0]       ch;
  logic [15:0]       idx;
  logic [15:0]       res_glyph;
  logic              res_fault;

  logic [15:0] end_mem   [MAX_SEGMENTS];
  logic [15:0] start_mem [MAX_SEGMENTS];
  logic [15:0] delta_mem [MAX_SEGMENTS];
  logic [15:0] ro_mem    [MAX_SEGMENTS];
  logic [15:0] word_mem  [GLYPH_ARRAY_WORDS];

  logic [15:0] end_q, start_q, delta_q, ro_q, word_q;

  logic        out_free;
  logic        seg_we;
  logic        word_we;
  logic [15:0] seg_wa;
  logic [15:0] word_wa;

  // the scan count is the count register saturated to the table depth
  assign n_seg = ({8'd0, segment_count} > 17'(MAX_SEGMENTS)) ?
                 SEG_CW'(MAX_SEGMENTS) : SEG_CW'(segment_count);

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == ST_IDLE) && !q_stat.empty;
  assign seg_we   = pop && (head.op == OP_SEG);
  assign word_we  = pop && (head.op == OP_WORD);
  assign seg_wa   = {8'd0, head.seg_slot};
  assign word_wa  = {4'd0, head.word_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= 9'd1;
    end else if (cfg_write) begin
      segment_count <= cfg_data;
    end
  end

  // segment tables, read address follows the scan index of the next cycle
  always_ff @(posedge clk) begin
    if (seg_we) begin
      end_mem[seg_wa[SEG_AW-1:0]]   <= head.end_code;
      start_mem[seg_wa[SEG_AW-1:0]] <= head.start_code;
      delta_mem[seg_wa[SEG_AW-1:0]] <= head.id_delta;
      ro_mem[seg_wa[SEG_AW-1:0]]    <= head.range_offset;
    end
    if (17'(s_next) < 17'(MAX_SEGMENTS)) begin
      end_q   <= end_mem[s_next[SEG_AW-1:0]];
      start_q <= start_mem[s_next[SEG_AW-1:0]];
      delta_q <= delta_mem[s_next[SEG_AW-1:0]];
      ro_q    <= ro_mem[s_next[SEG_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (word_we) begin
      word_mem[word_wa[GW_AW-1:0]] <= head.word_value;
    end
    if ({1'b0, idx} < 17'(GLYPH_ARRAY_WORDS)) begin
      word_q <= word_mem[idx[GW_AW-1:0]];
    end
  end

  always_comb begin
    state_next = state;
    s_next     = s;
    unique case (state)
      ST_IDLE: begin
        if (pop && head.op == OP_LOOKUP) begin
          s_next = '0;
          if (head.big || n_seg == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (end_q >= ch) begin
          if (start_q > ch || ro_q == 16'd0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_IDX;
          end
        end else if (SEG_CW'(s + 1'b1) == n_seg) begin
          state_next = ST_DONE;
        end else begin
          s_next = SEG_CW'(s + 1'b1);
        end
      end
      ST_IDX: begin
        if ({1'b0, idx} >= 17'(GLYPH_ARRAY_WORDS)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_GRD;
        end
      end
      ST_GRD: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      s     <= '0;
    end else begin
      state <= state_next;
      s     <= s_next;
    end
  end

  // lookup datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        ch        <= head.ch;
        res_glyph <= 16'd0;
        res_fault <= 1'b0;
      end
      ST_CMP: begin
        if (end_q >= ch && start_q <= ch && ro_q == 16'd0) begin
          res_glyph <= 16'(delta_q + ch);
        end
        idx <= 16'(ro_q[15:1] - 16'(n_seg) + 16'(s) + 16'(ch - start_q));
      end
      ST_IDX: begin
        if ({1'b0, idx} >= 17'(GLYPH_ARRAY_WORDS)) begin
          res_fault <= 1'b1;
        end
      end
      ST_GRD: begin
        // a zero word stays the missing glyph
        if (word_q != 16'd0) begin
          res_glyph <= 16'(word_q + delta_q);
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      glyph_id    <= res_glyph;
      index_fault <= res_fault;
    end
  end

endmodule

FILE: hdl/cmap_format4_char_to_glyph.sv
// top level of the cmap format 4 character to glyph mapper
//
// input channel (in_valid / in_stall) carries one item per transaction:
//   mode 0 looks up char_code, mode 1 loads one segment at seg_slot,
//   mode 2 loads one glyph array word at word_slot, mode 3 is dropped.
// only lookups produce a transaction on the output channel
// (out_valid / out_stall) with glyph_id and index_fault.
// cfg_write / cfg_data load segment_count; write it only while idle.
// a front end classifies items into a four-entry command queue, the back
// end runs the segment scan against its table memories.
// sequencing: a load is written to its table as it leaves the queue. a lookup
// scans one segment per cycle over the end code memory, reads the glyph
// array word when the range offset is nonzero and puts its result in the
// output register; the back end pops no new command before then.
// reset clears the queue, the scan sequencer and the output valid flag and
// sets segment_count to 1; table contents are undefined until loaded.
// while the receiver stalls the result holds, the back end finishes the
// next lookup and waits; loads keep flowing until the queue fills.
module cmap_format4_char_to_glyph #(
  parameter int MAX_SEGMENTS = cmap4_pkg::DEF_MAX_SEGMENTS,
  parameter int GLYPH_ARRAY_WORDS = cmap4_pkg::DEF_GLYPH_ARRAY_WORDS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [20:0] char_code,
  input  logic [7:0]  seg_slot,
  input  logic [15:0] seg_end_code,
  input  logic [15:0] seg_start_code,
  input  logic [15:0] seg_id_delta,
  input  logic [15:0] seg_range_offset,
  input  logic [11:0] word_slot,
  input  logic [15:0] word_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] glyph_id,
  output logic        index_fault
);
  import cmap4_pkg::*;

  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    head;
  logic    push;
  logic    pop;

  cmap4_front #(
    .MAX_SEGMENTS      (MAX_SEGMENTS),
    .GLYPH_ARRAY_WORDS (GLYPH_ARRAY_WORDS)
  ) u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .char_code        (char_code),
    .seg_slot         (seg_slot),
    .seg_end_code     (seg_end_code),
    .seg_start_code   (seg_start_code),
    .seg_id_delta     (seg_id_delta),
    .seg_range_offset (seg_range_offset),
    .word_slot        (word_slot),
    .word_value       (word_value),
    .q_stat           (q_stat),
    .push             (push),
    .push_cmd         (push_cmd)
  );

  cmap4_fifo #(
    .WIDTH ($bits(cmd_t))
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .pop_data  (head),
    .q_stat    (q_stat)
  );

  cmap4_back #(
    .MAX_SEGMENTS      (MAX_SEGMENTS),
    .GLYPH_ARRAY_WORDS (GLYPH_ARRAY_WORDS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .q_stat      (q_stat),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .glyph_id    (glyph_id),
    .index_fault (index_fault)
  );

endmodule

FILE: hdl/cmap4_checker.sv
// port-level checks for the cmap format 4 mapper, bound to the top level
module cmap4_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  mode,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] glyph_id,
  input logic        index_fault
);
  import cmap4_pkg::*;

  logic [3:0] pending;
  logic       lookup_in;
  logic       result_out;

  assign lookup_in  = in_valid && !in_stall && mode == MODE_LOOKUP;
  assign result_out = out_valid && !out_stall;

  // lookups accepted whose result has not been taken yet
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (lookup_in && !result_out) begin
      pending <= 4'(pending + 1'b1);
    end else if (result_out && !lookup_in) begin
      pending <= 4'(pending - 1'b1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(glyph_id) && $stable(index_fault))
    else $error("result changed while stalled");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_fault |-> glyph_id == 16'd0)
    else $error("index fault with nonzero glyph");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 4'd0)
    else $error("result without an outstanding lookup");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind cmap_format4_char_to_glyph cmap4_checker u_cmap4_checker (.*);

FILE: dv/tb_cmap_format4_char_to_glyph.sv
// self-checking testbench for the cmap format 4 character to glyph mapper
module tb_cmap_format4_char_to_glyph;
  timeunit 1ns;
  timeprecision 1ps;
  import cmap4_pkg::*;

  localparam int NSEG = DEF_MAX_SEGMENTS;
  localparam int NWORDS = DEF_GLYPH_ARRAY_WORDS;
  localparam int LIVE = 0;
  localparam int PLAN = 1;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_PER_PHASE = 50;

  typedef struct packed {
    mode_t       mode;
    logic        drain_first;
    logic [20:0] ch;
    logic [7:0]  seg_slot;
    logic [15:0] end_code;
    logic [15:0] start_code;
    logic [15:0] id_delta;
    logic [15:0] range_offset;
    logic [11:0] word_slot;
    logic [15:0] word_value;
  } cmap_item_t;

  typedef struct packed {
    logic [15:0] glyph;
    logic        fault;
  } glyph_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [8:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = '0;
  logic [20:0] char_code = '0;
  logic [7:0]  seg_slot = '0;
  logic [15:0] seg_end_code = '0;
  logic [15:0] seg_start_code = '0;
  logic [15:0] seg_id_delta = '0;
  logic [15:0] seg_range_offset = '0;
  logic [11:0] word_slot = '0;
  logic [15:0] word_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] glyph_id;
  logic        index_fault;

  cmap_format4_char_to_glyph dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .char_code(char_code),
    .seg_slot(seg_slot),
    .seg_end_code(seg_end_code),
    .seg_start_code(seg_start_code),
    .seg_id_delta(seg_id_delta),
    .seg_range_offset(seg_range_offset),
    .word_slot(word_slot),
    .word_value(word_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .glyph_id(glyph_id),
    .index_fault(index_fault)
  );

  // two copies of the tables: LIVE follows accepted transactions, PLAN follows
  // the generator so it can tell which glyph words a lookup will touch
  logic [15:0] end_mem    [2][NSEG];
  logic [15:0] start_mem  [2][NSEG];
  logic [15:0] delta_mem  [2][NSEG];
  logic [15:0] offset_mem [2][NSEG];
  logic [15:0] word_mem   [2][NWORDS];
  bit          word_known [NWORDS];
  logic [8:0]  seg_count = 9'd1;

  cmap_item_t    cmap_items[$];
  glyph_result_t expected_glyphs[$];
  cmap_item_t    cur_item;
  glyph_result_t want;

  int cycle_count = 0;
  int fail_count = 0;
  int items_accepted = 0;
  int lookups_checked = 0;
  int faults_seen = 0;
  int missing_glyphs = 0;
  int settings_used = 0;
  int in_gap = 0;
  int in_calm = 0;
  int out_hold = 0;
  int out_calm = 0;
  int phase_counts[7] = '{1, 7, 0, 30, 256, 511, 5};

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // mostly short idles, a few long ones, and now and then a calm stretch
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(40, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void map_char_to_glyph(input int bank, input logic [20:0] ch,
                                            output logic [15:0] glyph, output logic fault,
                                            output logic reads_word,
                                            output logic [11:0] word_idx);
    int n, s, idx;
    logic [15:0] w;
    glyph = '0;
    fault = 1'b0;
    reads_word = 1'b0;
    word_idx = '0;
    n = (seg_count > NSEG) ? NSEG : seg_count;
    s = 0;
    while (s < n && end_mem[bank][s] < ch) s++;
    if (s < n && start_mem[bank][s] <= ch) begin
      if (offset_mem[bank][s] == 16'd0) begin
        glyph = delta_mem[bank][s] + ch[15:0];
      end else begin
        idx = ((offset_mem[bank][s] >> 1) - n + s + (ch[15:0] - start_mem[bank][s]))
              & 'hFFFF;
        if (idx >= NWORDS) begin
          fault = 1'b1;
        end else begin
          reads_word = 1'b1;
          word_idx = idx[11:0];
          w = word_mem[bank][idx];
          // a zero word stays the missing glyph, delta is not added
          glyph = (w == 16'd0) ? 16'd0 : w + delta_mem[bank][s];
        end
      end
    end
  endfunction

  // slots are as wide as the tables, so no write can fall outside them
  function automatic void apply_item(input int bank, input cmap_item_t it);
    case (it.mode)
      MODE_SEG: begin
        end_mem[bank][it.seg_slot] = it.end_code;
        start_mem[bank][it.seg_slot] = it.start_code;
        delta_mem[bank][it.seg_slot] = it.id_delta;
        offset_mem[bank][it.seg_slot] = it.range_offset;
      end
      MODE_WORD: word_mem[bank][it.word_slot] = it.word_value;
      default: ;
    endcase
  endfunction

  function automatic cmap_item_t rand_item();
    cmap_item_t it;
    it.mode = MODE_NONE;
    it.drain_first = 1'b0;
    it.ch = 21'($urandom_range(0, 1114111));
    it.seg_slot = 8'($urandom);
    it.end_code = 16'($urandom);
    it.start_code = 16'($urandom);
    it.id_delta = 16'($urandom);
    it.range_offset = 16'($urandom);
    it.word_slot = 12'($urandom);
    it.word_value = 16'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] rand_word();
    logic [15:0] w;
    w = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
    return w;
  endfunction

  task automatic push_item(input cmap_item_t it);
    apply_item(PLAN, it);
    if (it.mode == MODE_WORD) word_known[it.word_slot] = 1'b1;
    cmap_items.push_back(it);
  endtask

  task automatic push_seg(input logic [7:0] slot, input logic [15:0] e,
                          input logic [15:0] st, input logic [15:0] d,
                          input logic [15:0] ro);
    cmap_item_t it;
    it = rand_item();
    it.mode = MODE_SEG;
    it.seg_slot = slot;
    it.end_code = e;
    it.start_code = st;
    it.id_delta = d;
    it.range_offset = ro;
    push_item(it);
  endtask

  task automatic push_word(input logic [11:0] slot, input logic [15:0] v);
    cmap_item_t it;
    it = rand_item();
    it.mode = MODE_WORD;
    it.word_slot = slot;
    it.word_value = v;
    push_item(it);
  endtask

  // a glyph word that was never loaded gets loaded just before the lookup
  task automatic push_lookup(input logic [20:0] ch, input bit drain);
    cmap_item_t it;
    logic [15:0] g;
    logic f, rd;
    logic [11:0] wi;
    map_char_to_glyph(PLAN, ch, g, f, rd, wi);
    if (rd && !word_known[wi]) push_word(wi, rand_word());
    it = rand_item();
    it.mode = MODE_LOOKUP;
    it.ch = ch;
    it.drain_first = drain;
    push_item(it);
  endtask

  function automatic logic [20:0] pick_char();
    int n, s, span, r;
    logic [20:0] ch;
    n = (seg_count > NSEG) ? NSEG : seg_count;
    r = $urandom_range(0, 15);
    if (r == 0) begin
      ch = 21'($urandom_range('h10000, 1114111));
    end else if (r <= 2 || n == 0) begin
      ch = 21'($urandom_range(0, 'hFFFF));
    end else begin
      s = $urandom_range(0, n - 1);
      span = int'(end_mem[PLAN][s]) - int'(start_mem[PLAN][s]);
      if (span < 0) span = 0;
      if (span > 64) span = 64;
      if (r == 3) ch = 21'(end_mem[PLAN][s]);
      else ch = 21'(start_mem[PLAN][s] + $urandom_range(0, span));
    end
    return ch;
  endfunction

  // sorted end codes ending at 0xffff, some gaps below start codes, offsets
  // that land inside the glyph array, with a few raw ones that mostly fault
  task automatic build_segments(input int n);
    int step, prev_end, e, st, gap, kind, base;
    logic [15:0] ro;
    step = 65536 / n;
    prev_end = -1;
    for (int s = 0; s < n; s++) begin
      e = (s == n - 1) ? 65535 : (s + 1) * step - 1 - $urandom_range(0, step / 4);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
      st = prev_end + 1 + gap;
      kind = $urandom_range(0, 7);
      if (kind < 3) begin
        ro = '0;
      end else if (kind == 3) begin
        ro = 16'($urandom);
      end else begin
        base = $urandom_range(0, 4000);
        ro = 16'(2 * (base + n - s));
      end
      push_seg(8'(s), 16'(e), 16'(st), 16'($urandom), ro);
      prev_end = e;
    end
  endtask

  task automatic random_traffic(input int quota);
    int done, r;
    cmap_item_t it;
    done = 0;
    while (done < quota) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        push_lookup(pick_char(), $urandom_range(0, 59) == 0);
        done++;
      end else if (r < 78) begin
        it = rand_item();
        it.mode = MODE_SEG;
        push_item(it);
        done++;
      end else if (r < 92) begin
        push_word(12'($urandom_range(0, NWORDS - 1)), rand_word());
        done++;
      end else begin
        push_item(rand_item());
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (cmap_items.size() != 0 || in_valid || expected_glyphs.size() != 0);
  endtask

  task automatic write_count(input logic [8:0] v);
    wait_idle();
    // loads and dropped items may still sit in the block's queue
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    seg_count = v;
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // input side
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        logic [15:0] g;
        logic f, rd;
        logic [11:0] wi;
        apply_item(LIVE, cur_item);
        if (cur_item.mode == MODE_LOOKUP) begin
          map_char_to_glyph(LIVE, cur_item.ch, g, f, rd, wi);
          expected_glyphs.push_back('{glyph: g, fault: f});
        end
        items_accepted++;
        in_gap = idle_len(in_calm);
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (cmap_items.size() != 0 &&
                     !(cmap_items[0].drain_first && expected_glyphs.size() != 0)) begin
          cur_item = cmap_items.pop_front();
          mode <= cur_item.mode;
          char_code <= cur_item.ch;
          seg_slot <= cur_item.seg_slot;
          seg_end_code <= cur_item.end_code;
          seg_start_code <= cur_item.start_code;
          seg_id_delta <= cur_item.id_delta;
          seg_range_offset <= cur_item.range_offset;
          word_slot <= cur_item.word_slot;
          word_value <= cur_item.word_value;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_glyphs.size() == 0) begin
          $error("result with no lookup pending: glyph_id %h index_fault %b",
                 glyph_id, index_fault);
          fail_count++;
        end else begin
          want = expected_glyphs.pop_front();
          if (glyph_id !== want.glyph) begin
            $error("glyph_id mismatch: expected %h, got %h", want.glyph, glyph_id);
            fail_count++;
          end
          if (index_fault !== want.fault) begin
            $error("index_fault mismatch: expected %b, got %b", want.fault, index_fault);
            fail_count++;
          end
          lookups_checked++;
          if (want.fault) faults_seen++;
          if (want.glyph == 16'd0) missing_glyphs++;
        end
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
        out_hold = idle_len(out_calm);
      end
    end
  end

  initial begin
    cmap_item_t it;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // hand-built two segment table: delta wrap, start above char, zero word,
    // word plus delta wrap, index past the array, codes above 0xffff
    write_count(9'd2);
    push_seg(8'd0, 16'h0040, 16'h0020, 16'hFFF0, 16'h0000);
    push_seg(8'd1, 16'hFFFF, 16'h1000, 16'h0005, 16'd22);
    push_seg(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_word(12'd10, 16'h1234);
    push_word(12'd11, 16'h0000);
    push_word(12'd12, 16'hFFFF);
    push_word(12'(NWORDS - 1), 16'hFFFF);
    push_lookup(21'h000000, 1'b0);
    push_lookup(21'h000020, 1'b0);
    push_lookup(21'h000040, 1'b0);
    push_lookup(21'h000041, 1'b0);
    push_lookup(21'h000FFF, 1'b0);
    push_lookup(21'h001000, 1'b0);
    push_lookup(21'h001001, 1'b0);
    push_lookup(21'h001002, 1'b1);
    push_lookup(21'h00FFFF, 1'b0);
    push_lookup(21'h010000, 1'b0);
    push_lookup(21'd1114111, 1'b0);
    it = rand_item();
    it.ch = 21'd1114111;
    it.seg_slot = '1;
    it.end_code = '1;
    it.start_code = '1;
    it.id_delta = '1;
    it.range_offset = '1;
    it.word_slot = '1;
    it.word_value = '1;
    push_item(it);

    phase_counts[6] = $urandom_range(2, 20);
    foreach (phase_counts[p]) begin
      write_count(9'(phase_counts[p]));
      // zero count scans nothing; counts past the table reuse all segments
      if (phase_counts[p] >= 1 && phase_counts[p] <= NSEG) build_segments(phase_counts[p]);
      random_traffic(RANDOM_PER_PHASE);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d accepted transactions over %0d segment count settings",
             items_accepted, settings_used);
    $display("checked %0d lookups: %0d index faults, %0d missing glyphs",
             lookups_checked, faults_seen, missing_glyphs);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/cmap4_pkg.sv
hdl/cmap4_front.sv
hdl/cmap4_fifo.sv
hdl/cmap4_back.sv
hdl/cmap_format4_char_to_glyph.sv
hdl/cmap4_checker.sv
dv/tb_cmap_format4_char_to_glyph.sv
